@@ hdl/spi_pkg.sv @@
package spi_pkg;

  localparam int NORM_SHIFT = 14;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_OFFSET    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ONE_SIDED = 3'd5;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic        [15:0] threshold;
    logic               one_sided;
  } cfg_t;

endpackage

@@ hdl/segment_plane_intersection.sv @@
// Throughput: one transaction per cycle when not stalled; one quotient bit per divider stage.
// The whole pipeline holds when a result waits at the output, so nothing is lost on a stall.
// Reset (rst, synchronous, active high) clears every valid bit and loads the configuration
// defaults: normal (0,0,1), offset 0, threshold 1, segment mode.
module segment_plane_intersection import spi_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  localparam int IN_W  = ((6*COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((FRACTION_BITS + 1 + 3*COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // start_x, start_y, start_z, second_x, second_y, second_z
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // fraction, point_x, point_y, point_z
  output logic [OUT_W-1:0]  m_tdata,
  // hit
  output logic [0:0]        m_tuser
);
  localparam int CW       = COORD_WIDTH;
  localparam int FB       = FRACTION_BITS;
  localparam int DW       = CW + 1;
  localparam int LW       = ((CW > 34) ? CW : 34) + 1;
  localparam int MW       = LW + 4;
  localparam int SW       = 1 + 3*CW + 3*DW;

  cfg_t cfg;
  logic en;

  logic            f_valid, f_ok;
  logic [MW-1:0]   f_an, f_ad;
  logic [3*CW-1:0] f_s;
  logic [3*DW-1:0] f_d;

  logic            q_valid;
  logic [FB:0]     q_quot;
  logic [SW-1:0]   q_side;

  logic            hit;
  logic [FB:0]     fraction;
  logic [3*CW-1:0] point;

  // Configuration register file; unknown indices drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_x     <= 16'sd0;
      cfg.normal_y     <= 16'sd0;
      cfg.normal_z     <= 16'sd16384;
      cfg.plane_offset <= 32'sd0;
      cfg.threshold    <= 16'd1;
      cfg.one_sided    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NORMAL_X:  cfg.normal_x     <= cfg_data[15:0];
        REG_NORMAL_Y:  cfg.normal_y     <= cfg_data[15:0];
        REG_NORMAL_Z:  cfg.normal_z     <= cfg_data[15:0];
        REG_OFFSET:    cfg.plane_offset <= cfg_data[31:0];
        REG_THRESHOLD: cfg.threshold    <= cfg_data[15:0];
        REG_ONE_SIDED: cfg.one_sided    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance every stage together whenever the output register is free or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Direction, dot products with the normal, parallel and range tests
  spi_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .start     (s_tdata[3*CW-1:0]),
    .second    (s_tdata[6*CW-1:3*CW]),
    .out_valid (f_valid),
    .out_ok    (f_ok),
    .out_an    (f_an),
    .out_ad    (f_ad),
    .out_s     (f_s),
    .out_d     (f_d)
  );

  // num/denom as a pipelined restoring divider; hit flag and geometry ride alongside
  spi_div #(.MW(MW), .FB(FB), .SW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .an        (f_an),
    .ad        (f_ad),
    .in_side   ({f_ok, f_d, f_s}),
    .out_valid (q_valid),
    .quot      (q_quot),
    .out_side  (q_side)
  );

  // Point along the direction, saturated; the last stage is the output register
  spi_point #(.CW(CW), .FB(FB)) u_point (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .ok        (q_side[SW-1]),
    .quot      (q_quot),
    .s         (q_side[3*CW-1:0]),
    .d         (q_side[3*CW+3*DW-1:3*CW]),
    .out_valid (m_tvalid),
    .hit       (hit),
    .fraction  (fraction),
    .point     (point)
  );

  assign m_tdata = OUT_W'({point, fraction});
  assign m_tuser = hit;

endmodule

@@ hdl/spi_front.sv @@
module spi_front import spi_pkg::*; #(
  parameter int CW = 32,
  localparam int LW   = ((CW > 34) ? CW : 34) + 1,
  localparam int NUMW = LW + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  input  logic [3*CW-1:0]         start,
  input  logic [3*CW-1:0]         second,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic [NUMW-1:0]         out_an,
  output logic [NUMW-1:0]         out_ad,
  output logic [3*CW-1:0]         out_s,
  output logic [3*(CW+1)-1:0]     out_d
);
  localparam int DW   = CW + 1;
  localparam int DPW  = DW + 2;
  localparam int DENW = DW + 4;
  localparam int LPW  = LW + 2;

  logic signed [15:0] nv [3];
  logic signed [33:0] pv [3];
  logic signed [47:0] pprod [3];

  logic                 v1, v2, v3, v4, v5;
  logic signed [CW-1:0] s1 [3], s2 [3], s3 [3], s4 [3], s5 [3];
  logic signed [DW-1:0] d1 [3], d2 [3], d3 [3], d4 [3], d5 [3];
  logic signed [DPW-1:0] dp2 [3];
  logic signed [LW-1:0]  l2 [3];
  logic signed [LPW-1:0] lp3 [3];
  logic signed [DENW-1:0] den3, den4;
  logic signed [NUMW-1:0] num4;
  logic signed [DW+15:0]  dprod [3];
  logic signed [LW+15:0]  lprod [3];

  logic [DENW-1:0]        aden;
  logic [NUMW-1:0]        anum;
  logic signed [DENW:0]   den_eps;
  logic                   pass_eps, pass_rng;

  assign nv[0] = cfg.normal_x;
  assign nv[1] = cfg.normal_y;
  assign nv[2] = cfg.normal_z;

  // plane point per axis depends on configuration only: refresh every cycle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pprod[i] = nv[i] * cfg.plane_offset;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pv[i] <= $signed(pprod[i][47:NORM_SHIFT]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod[i] = d1[i] * nv[i];
      lprod[i] = l2[i] * nv[i];
    end
  end

  always_comb begin
    aden     = den4[DENW-1] ? DENW'(-den4) : DENW'(den4);
    anum     = num4[NUMW-1] ? NUMW'(-num4) : NUMW'(num4);
    den_eps  = (DENW+1)'(den4) + $signed({{(DENW-16){1'b0}}, cfg.threshold});
    if (cfg.one_sided) begin
      pass_eps = (den_eps <= 0) && (den4 != 0);
    end else begin
      pass_eps = (aden >= DENW'(cfg.threshold)) && (den4 != 0);
    end
    if (den4 > 0) begin
      pass_rng = (num4 >= 0) && (num4 <= NUMW'(den4));
    end else begin
      pass_rng = (num4 <= 0) && (num4 >= NUMW'(den4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= $signed(start[i*CW +: CW]);
        if (cfg.one_sided) begin
          d1[i] <= DW'($signed(second[i*CW +: CW]));
        end else begin
          d1[i] <= DW'($signed(second[i*CW +: CW])) - DW'($signed(start[i*CW +: CW]));
        end
        s2[i]  <= s1[i];
        d2[i]  <= d1[i];
        dp2[i] <= $signed(dprod[i][DW+15:NORM_SHIFT]);
        l2[i]  <= LW'(pv[i]) - LW'(s1[i]);
        s3[i]  <= s2[i];
        d3[i]  <= d2[i];
        lp3[i] <= $signed(lprod[i][LW+15:NORM_SHIFT]);
        s4[i]  <= s3[i];
        d4[i]  <= d3[i];
        s5[i]  <= s4[i];
        d5[i]  <= d4[i];
      end
      den3   <= DENW'(dp2[0]) + DENW'(dp2[1]) + DENW'(dp2[2]);
      den4   <= den3;
      num4   <= NUMW'(lp3[0]) + NUMW'(lp3[1]) + NUMW'(lp3[2]);
      out_ok <= pass_eps && pass_rng;
      out_an <= anum;
      out_ad <= NUMW'(aden);
    end
  end

  assign out_valid = v5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_s[i*CW +: CW] = s5[i];
      out_d[i*DW +: DW] = d5[i];
    end
  end

endmodule

@@ hdl/spi_div.sv @@
module spi_div #(
  parameter int MW = 40,
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [MW-1:0] an,
  input  logic [MW-1:0] ad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [FB:0]   quot,
  output logic [SW-1:0] out_side
);
  localparam int RW = MW + 1;

  logic [RW-1:0] rr   [FB+1];
  logic [FB:0]   qq   [FB+1];
  logic          vv   [FB+1];
  logic [SW-1:0] side [FB+1];

  // one quotient bit per stage, restoring form
  for (genvar j = 0; j <= FB; j++) begin : g_stage
    logic [RW-1:0] r_in, r_out;
    logic [FB:0]   q_in;
    logic [MW-1:0] d_in;
    logic          v_in;
    logic [SW-1:0] s_in;
    logic [MW-1:0] dd;

    if (j == 0) begin : g_first
      assign r_in = RW'(an);
      assign q_in = '0;
      assign d_in = ad;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_next
      assign r_in = {rr[j-1][RW-2:0], 1'b0};
      assign q_in = {qq[j-1][FB-1:0], 1'b0};
      assign d_in = g_stage[j-1].dd;
      assign v_in = vv[j-1];
      assign s_in = side[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j] <= 1'b0;
      end else if (en) begin
        vv[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= RW'(d_in)) begin
          rr[j] <= r_in - RW'(d_in);
          qq[j] <= q_in | (FB+1)'(1);
        end else begin
          rr[j] <= r_in;
          qq[j] <= q_in;
        end
        dd      <= d_in;
        side[j] <= s_in;
      end
    end
  end

  assign out_valid = vv[FB];
  assign quot      = qq[FB];
  assign out_side  = side[FB];

endmodule

@@ hdl/spi_point.sv @@
module spi_point #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                ok,
  input  logic [FB:0]         quot,
  input  logic [3*CW-1:0]     s,
  input  logic [3*(CW+1)-1:0] d,
  output logic                out_valid,
  output logic                hit,
  output logic [FB:0]         fraction,
  output logic [3*CW-1:0]     point
);
  localparam int DW = CW + 1;
  localparam int PW = DW + FB + 1;
  localparam int OW = DW + 1;
  localparam int SUMW = CW + 3;

  logic                 v1, ok1;
  logic [FB:0]          q1;
  logic [OW-1:0]        off1 [3];
  logic                 neg1 [3];
  logic signed [CW-1:0] s1   [3];
  logic [DW-1:0]        mag  [3];
  logic [PW-1:0]        prod [3];
  logic signed [SUMW-1:0] sum [3];
  logic signed [SUMW-1:0] hi, lo;

  assign hi = SUMW'({1'b0, {(CW-1){1'b1}}});
  assign lo = -hi - SUMW'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = d[i*DW + DW-1] ? DW'(-$signed(d[i*DW +: DW])) : d[i*DW +: DW];
      prod[i] = PW'(mag[i]) * PW'(quot);
      if (neg1[i]) begin
        sum[i] = SUMW'(s1[i]) - SUMW'(off1[i]);
      end else begin
        sum[i] = SUMW'(s1[i]) + SUMW'(off1[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= ok;
      q1  <= quot;
      for (int i = 0; i < 3; i++) begin
        off1[i] <= prod[i][PW-1:FB];
        neg1[i] <= d[i*DW + DW-1];
        s1[i]   <= $signed(s[i*CW +: CW]);
      end
      hit      <= ok1;
      fraction <= ok1 ? q1 : '0;
      for (int i = 0; i < 3; i++) begin
        if (!ok1) begin
          point[i*CW +: CW] <= '0;
        end else if (sum[i] > hi) begin
          point[i*CW +: CW] <= hi[CW-1:0];
        end else if (sum[i] < lo) begin
          point[i*CW +: CW] <= lo[CW-1:0];
        end else begin
          point[i*CW +: CW] <= sum[i][CW-1:0];
        end
      end
    end
  end

endmodule

@@ hdl/spi_check.sv @@
module spi_check import spi_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  localparam int OUT_W = ((FRACTION_BITS + 1 + 3*COORD_WIDTH + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic [0:0]        m_tuser
);

  // a waiting result holds its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss with non-zero payload");

  // a hit fraction never exceeds one
  a_frac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[FRACTION_BITS:0] <= (FRACTION_BITS+1)'(1 << FRACTION_BITS))
    else $error("fraction above one");

  // input side stalls exactly when the output side does
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

bind segment_plane_intersection spi_check #(
  .COORD_WIDTH   (COORD_WIDTH),
  .FRACTION_BITS (FRACTION_BITS)
) u_spi_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ verif/segment_plane_intersection_tb.sv @@
module segment_plane_intersection_tb;
  import spi_pkg::*;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int IN_W  = 6 * CW;
  localparam int OUT_W = 120;          // 17 + 3*32 = 113 bits, padded up to whole bytes
  localparam int LATENCY = FB + 8;
  localparam logic [CFG_AW-1:0] REG_UNMAPPED = 3'd7;

  // One result of the intersection test.
  typedef struct {
    logic               hit;
    logic [FB:0]        fraction;
    logic signed [CW-1:0] px, py, pz;
  } isect_t;

  // One row of the directed table: the item, and optionally the result typed in by hand.
  typedef struct {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    bit                   typed;
    isect_t               want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic [0:0]        m_tuser;

  // Shadow copy of the plane registers, kept in step with every write.
  cfg_t    plane;
  isect_t  pending_hits[$];
  isect_t  typed_hits[$];    // hand-typed expectations, parallel to pending_hits
  bit      typed_flags[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_idle = 0;

  segment_plane_intersection #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) DUT (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  always #6 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(12 * 600000);
    $display("simulation failed");
    $finish;
  end

  // Arithmetic shift right floors for negative values, as the fixed-point maths needs.
  function automatic longint shr14(longint x);
    return x >>> NORM_SHIFT;
  endfunction

  function automatic longint project(longint a, longint b, longint c);
    return shr14(a * plane.normal_x) + shr14(b * plane.normal_y) + shr14(c * plane.normal_z);
  endfunction

  // Move from s along d by fraction q, saturating to the coordinate range.
  function automatic logic signed [CW-1:0] walk(longint s, longint d, longint unsigned q);
    longint unsigned mag, off;
    longint r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    off = (mag >> FB) * q + (((mag & 64'hFFFF) * q) >> FB);
    r   = (d < 0) ? s - longint'(off) : s + longint'(off);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[CW-1:0];
  endfunction

  // Predict the crossing of one segment or ray with the configured plane.
  function automatic isect_t predict(logic [IN_W-1:0] item);
    longint s[3], d[3], l[3], p[3];
    longint den, num, eps;
    longint unsigned an, ad, r, q;
    bit ok;
    isect_t res;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(item[i*CW +: CW]));
      d[i] = longint'($signed(item[(i+3)*CW +: CW]));
      if (!plane.one_sided) d[i] -= s[i];
    end
    p[0] = shr14(longint'(plane.normal_x) * plane.plane_offset);
    p[1] = shr14(longint'(plane.normal_y) * plane.plane_offset);
    p[2] = shr14(longint'(plane.normal_z) * plane.plane_offset);
    for (int i = 0; i < 3; i++) l[i] = p[i] - s[i];
    den = project(d[0], d[1], d[2]);
    num = project(l[0], l[1], l[2]);
    eps = longint'(plane.threshold);
    // reject back-facing rays or near-parallel segments; a zero denominator always fails
    if (plane.one_sided) ok = !(den > -eps) && den != 0;
    else                 ok = !(((den < 0) ? -den : den) < eps) && den != 0;
    if (ok) ok = (den > 0) ? (num >= 0 && num <= den) : (num <= 0 && num >= den);
    res = '{1'b0, '0, '0, '0, '0};
    if (!ok) return res;
    an = (num < 0) ? longint'(-num) : longint'(num);
    ad = (den < 0) ? longint'(-den) : longint'(den);
    r = an;
    q = 0;
    if (r >= ad) begin q = 1; r -= ad; end
    for (int i = 0; i < FB; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= ad) begin q |= 1; r -= ad; end
    end
    res.hit      = 1'b1;
    res.fraction = q[FB:0];
    res.px = walk(s[0], d[0], q);
    res.py = walk(s[1], d[1], q);
    res.pz = walk(s[2], d[2], q);
    return res;
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NORMAL_X:  plane.normal_x     = val[15:0];
      REG_NORMAL_Y:  plane.normal_y     = val[15:0];
      REG_NORMAL_Z:  plane.normal_z     = val[15:0];
      REG_OFFSET:    plane.plane_offset = val[31:0];
      REG_THRESHOLD: plane.threshold    = val[15:0];
      REG_ONE_SIDED: plane.one_sided    = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one transaction; s_tvalid stays high into the next call unless a gap is drawn.
  task automatic send(logic [IN_W-1:0] item, bit typed = 0, isect_t want = '{0, 0, 0, 0, 0});
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
    pending_hits.push_back(predict(item));
    typed_flags.push_back(typed);
    typed_hits.push_back(want);
  endtask

  // Hold off until every expected result has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random, check each result against the oldest expectation.
  always @(posedge clk) begin
    isect_t want;
    bit     typed;
    isect_t hand;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        want  = pending_hits.pop_front();
        typed = typed_flags.pop_front();
        hand  = typed_hits.pop_front();
        if (typed) want = hand;
        if (m_tuser[0] !== want.hit) report("hit", m_tuser[0], want.hit);
        if (m_tdata[16:0] !== want.fraction) report("fraction", m_tdata[16:0], want.fraction);
        if (m_tdata[48:17] !== want.px) report("point_x", $signed(m_tdata[48:17]), want.px);
        if (m_tdata[80:49] !== want.py) report("point_y", $signed(m_tdata[80:49]), want.py);
        if (m_tdata[112:81] !== want.pz) report("point_z", $signed(m_tdata[112:81]), want.pz);
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [IN_W-1:0] pack_item(logic signed [CW-1:0] sx, sy, sz, ex, ey, ez);
    return {ez, ey, ex, sz, sy, sx};
  endfunction

  // Coordinate biased towards the plane neighbourhood, with full-range noise now and then.
  function automatic logic signed [CW-1:0] coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $signed(32'($urandom_range(1 << 23))) - (1 << 22);
    if (pick < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  row_t directed[] = '{
    // crossing at the midpoint of a segment through the origin plane
    '{0, 0, -32'sd65536, 0, 0, 32'sd65536, 1, '{1, 17'd32768, 0, 0, 0}},
    // segment lying in a parallel plane
    '{0, 0, 32'sd65536, 32'sd65536, 0, 32'sd65536, 1, '{0, 0, 0, 0, 0}},
    // segment entirely above the plane
    '{0, 0, 32'sd65536, 0, 0, 32'sd131072, 1, '{0, 0, 0, 0, 0}},
    // touching at the start point
    '{0, 0, 0, 0, 0, 32'sd65536, 1, '{1, 17'd0, 0, 0, 0}},
    // touching at the end point
    '{0, 0, -32'sd65536, 0, 0, 0, 1, '{1, 17'd65536, 0, 0, 0}},
    // full-range corners
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{0, 0, 0, 0, 0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0, 0, 0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
      0, '{0, 0, 0, 0, 0}},
    // denominator exactly at the threshold of one unit
    '{0, 0, 0, 0, 0, 32'sd1, 0, '{0, 0, 0, 0, 0}},
    // start and end identical: zero denominator
    '{32'sd5, 32'sd7, 32'sd9, 32'sd5, 32'sd7, 32'sd9, 1, '{0, 0, 0, 0, 0}},
    // downward crossing, fraction one quarter
    '{32'sd100, -32'sd200, 32'sd65536, 32'sd500, 32'sd200, -32'sd196608, 0, '{0, 0, 0, 0, 0}},
    // long segment between full-range end points
    '{32'h7FFF_0000, 0, -32'sd1, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    logic [IN_W-1:0] item;
    plane = '{16'sd0, 16'sd0, 16'sd16384, 32'sd0, 16'd1, 1'b0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset configuration
    send_idle = 35;
    recv_idle = 76;
    foreach (directed[i])
      send(pack_item(directed[i].sx, directed[i].sy, directed[i].sz,
                     directed[i].ex, directed[i].ey, directed[i].ez),
           directed[i].typed, directed[i].want);
    drain();

    // one-sided mode with a zero threshold, then the largest threshold
    write_reg(REG_ONE_SIDED, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    send(pack_item(0, 0, 32'sd65536, 0, 0, -32'sd131072));
    send(pack_item(0, 0, -32'sd65536, 0, 0, 32'sd131072));
    send(pack_item(0, 0, 32'sd65536, 0, 0, 0));
    drain();
    write_reg(REG_THRESHOLD, 32'd65535);
    write_reg(REG_OFFSET, 32'h8000_0000);
    write_reg(REG_NORMAL_X, 32'hFFFF_C000);
    write_reg(REG_NORMAL_Y, 32'd16384);
    write_reg(REG_NORMAL_Z, 32'hFFFF_C000);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);   // unmapped index: dropped
    send(pack_item(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3));
    send(pack_item(0, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000));
    drain();

    // random phases, each under a fresh plane
    for (int ph = 0; ph < 15; ph++) begin
      if (ph < 5) begin send_idle = 35; recv_idle = 76; end
      else if (ph < 10) begin send_idle = 76; recv_idle = 35; end
      else begin send_idle = 0; recv_idle = 0; end
      write_reg(REG_NORMAL_X, {{16{1'b0}}, pick_normal()});
      write_reg(REG_NORMAL_Y, {{16{1'b0}}, pick_normal()});
      write_reg(REG_NORMAL_Z, {{16{1'b0}}, pick_normal()});
      case (ph % 4)
        0: write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        1: write_reg(REG_OFFSET, 32'h8000_0000);
        default: write_reg(REG_OFFSET, $signed(32'($urandom_range(1 << 22))) - (1 << 21));
      endcase
      case (ph % 3)
        0: write_reg(REG_THRESHOLD, 32'd0);
        1: write_reg(REG_THRESHOLD, 32'd65535);
        default: write_reg(REG_THRESHOLD, $urandom_range(200));
      endcase
      write_reg(REG_ONE_SIDED, ph % 2);
      for (int n = 0; n < 110; n++) begin
        item = pack_item(coord(), coord(), coord(), coord(), coord(), coord());
        send(item);
        if (ph == 7 && n == 55) drain();   // hold the sender until the pipe is empty
      end
      drain();
    end

    repeat (LATENCY + 6) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
